[sv/i2cbm_pkg.sv]
package i2cbm_pkg;

   // Phase codes of the command sequencer
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_STOP   = 3'd2;
   localparam logic [2:0] PH_PUT    = 3'd3;
   localparam logic [2:0] PH_PUTACK = 3'd4;
   localparam logic [2:0] PH_GET    = 3'd5;
   localparam logic [2:0] PH_GETACK = 3'd6;

   // Command codes of an input item
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_START      = 3'd1;
   localparam logic [2:0] CMD_STOP       = 3'd2;
   localparam logic [2:0] CMD_WRITE      = 3'd3;
   localparam logic [2:0] CMD_READ       = 3'd4;
   localparam logic [2:0] CMD_ADDR_WRITE = 3'd5;
   localparam logic [2:0] CMD_ADDR_READ  = 3'd6;
   localparam logic [2:0] CMD_RESERVED   = 3'd7;

   // Line actions taken in the first cycle of a line operation
   localparam logic [3:0] A_NONE       = 4'd0;
   localparam logic [3:0] A_SDA_REL    = 4'd1;
   localparam logic [3:0] A_SDA_LOW    = 4'd2;
   localparam logic [3:0] A_SCL_REL    = 4'd3;
   localparam logic [3:0] A_SCL_LOW    = 4'd4;
   localparam logic [3:0] A_SDA_BIT    = 4'd5;
   localparam logic [3:0] A_SCL_SAMPLE = 4'd6;
   localparam logic [3:0] A_ACK_SAMPLE = 4'd7;
   localparam logic [3:0] A_SDA_ACK    = 4'd8;

   // Configuration register indexes
   localparam logic REG_QUARTER_TICKS  = 1'b0;
   localparam logic REG_DEVICE_ADDRESS = 1'b1;

   localparam logic [15:0] QUARTER_TICKS_RESET = 16'd125;
   localparam logic [2:0]  LAST_BIT            = 3'd7;

   typedef struct packed {
      logic [3:0] act;
      logic [1:0] quarters;
   } line_op_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic       ack_received;
      logic [7:0] read_data;
   } result_type;

   // Number of line operations in a phase
   function automatic logic [2:0] phase_len(input logic [2:0] ph);
      logic [2:0] len;
      case (ph)
         PH_START, PH_STOP:          len = 3'd4;
         PH_PUT, PH_PUTACK, PH_GET:  len = 3'd3;
         default:                    len = 3'd5;
      endcase
      return len;
   endfunction

   // Line operation table, one entry per phase and step
   function automatic line_op_type line_op(input logic [2:0] ph, input logic [2:0] step);
      line_op_type op;
      op = '{act: A_NONE, quarters: 2'd0};
      case (ph)
         PH_START: begin
            case (step)
               3'd0:    op = '{act: A_SDA_REL, quarters: 2'd2};
               3'd1:    op = '{act: A_SCL_REL, quarters: 2'd2};
               3'd2:    op = '{act: A_SDA_LOW, quarters: 2'd2};
               default: op = '{act: A_SCL_LOW, quarters: 2'd2};
            endcase
         end
         PH_STOP: begin
            case (step)
               3'd0:    op = '{act: A_NONE,    quarters: 2'd2};
               3'd1:    op = '{act: A_SDA_LOW, quarters: 2'd2};
               3'd2:    op = '{act: A_SCL_REL, quarters: 2'd2};
               default: op = '{act: A_SDA_REL, quarters: 2'd2};
            endcase
         end
         PH_PUT: begin
            case (step)
               3'd0:    op = '{act: A_SDA_BIT, quarters: 2'd1};
               3'd1:    op = '{act: A_SCL_REL, quarters: 2'd1};
               default: op = '{act: A_SCL_LOW, quarters: 2'd0};
            endcase
         end
         PH_PUTACK: begin
            case (step)
               3'd0:    op = '{act: A_SDA_REL,    quarters: 2'd1};
               3'd1:    op = '{act: A_SCL_REL,    quarters: 2'd2};
               default: op = '{act: A_ACK_SAMPLE, quarters: 2'd0};
            endcase
         end
         PH_GET: begin
            case (step)
               3'd0:    op = '{act: A_SDA_REL,    quarters: 2'd1};
               3'd1:    op = '{act: A_SCL_SAMPLE, quarters: 2'd1};
               default: op = '{act: A_SCL_LOW,    quarters: 2'd0};
            endcase
         end
         default: begin
            case (step)
               3'd0:    op = '{act: A_NONE,    quarters: 2'd1};
               3'd1:    op = '{act: A_SDA_ACK, quarters: 2'd1};
               3'd2:    op = '{act: A_SCL_REL, quarters: 2'd1};
               3'd3:    op = '{act: A_SCL_LOW, quarters: 2'd0};
               default: op = '{act: A_SDA_REL, quarters: 2'd0};
            endcase
         end
      endcase
      return op;
   endfunction

endpackage

[sv/i2cbm_if.sv]
interface i2cbm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] write_data;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, output command, output write_data, output send_nack,
                   output sda_in, input ready);
   modport sink   (input valid, input command, input write_data, input send_nack,
                   input sda_in, output ready);
endinterface

interface i2cbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_release;
   logic       sda_release;
   logic       busy_res;
   logic       done_res;
   logic       ack_received;
   logic [7:0] read_data;

   modport source (output valid, output scl_release, output sda_release, output busy_res,
                   output done_res, output ack_received, output read_data, input ready);
   modport sink   (input valid, input scl_release, input sda_release, input busy_res,
                   input done_res, input ack_received, input read_data, output ready);
endinterface

[sv/i2cbm_core.sv]
module i2cbm_core import i2cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [2:0]  command,
   input  logic [7:0]  write_data,
   input  logic        send_nack,
   input  logic        sda_in,
   input  logic [15:0] quarter_ticks,
   input  logic [6:0]  device_address,
   output result_type  result
);

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] tick_ff, tick_in;
   logic [1:0]  quarter_ff, quarter_in;
   logic        nack_ff, nack_in;
   logic        ack_ff, ack_in;
   logic        scl_ff, scl_in;
   logic        sda_lvl_ff, sda_lvl_in;
   logic        chain_ff, chain_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic        done;

   // Advance the sequencer once for each accepted item
   always_comb begin
      logic [2:0]  len;
      line_op_type op;
      logic [15:0] qt;
      logic [16:0] tick_sum;
      logic [1:0]  quarter_sum;
      logic        advance;

      phase_in   = phase_ff;
      step_in    = step_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      quarter_in = quarter_ff;
      nack_in    = nack_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_lvl_in = sda_lvl_ff;
      chain_in   = chain_ff;
      rbyte_in   = rbyte_ff;
      done       = 1'b0;
      len        = phase_len(phase_ff);
      op         = line_op(phase_ff, 3'd0);
      qt         = (quarter_ticks == 16'd0) ? 16'd1 : quarter_ticks;
      tick_sum   = '0;
      quarter_sum = '0;
      advance    = 1'b0;

      if (accept) begin
         // launch a new command from idle
         if (phase_ff == PH_IDLE && (command inside {[CMD_START:CMD_ADDR_READ]})) begin
            step_in    = '0;
            tick_in    = '0;
            quarter_in = '0;
            bit_in     = '0;
            chain_in   = 1'b0;
            case (command)
               CMD_START: phase_in = PH_START;
               CMD_STOP:  phase_in = PH_STOP;
               CMD_WRITE: begin
                  shift_in = write_data;
                  phase_in = PH_PUT;
               end
               CMD_READ: begin
                  nack_in  = send_nack;
                  shift_in = '0;
                  phase_in = PH_GET;
               end
               default: begin
                  shift_in = {device_address, command == CMD_ADDR_READ};
                  chain_in = 1'b1;
                  phase_in = PH_START;
               end
            endcase
         end

         if (phase_in != PH_IDLE) begin
            len = phase_len(phase_in);
            if (step_in >= len) begin
               step_in = '0;
            end
            op = line_op(phase_in, step_in);

            // drive pins or sample in the first cycle of an operation
            if (tick_in == 16'd0 && quarter_in == 2'd0) begin
               case (op.act)
                  A_SDA_REL: sda_lvl_in = 1'b1;
                  A_SDA_LOW: sda_lvl_in = 1'b0;
                  A_SCL_REL: scl_in = 1'b1;
                  A_SCL_LOW: scl_in = 1'b0;
                  A_SDA_BIT: begin
                     sda_lvl_in = shift_in[7];
                     shift_in   = {shift_in[6:0], 1'b0};
                  end
                  A_SCL_SAMPLE: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_in[6:0], sda_in};
                  end
                  A_ACK_SAMPLE: begin
                     ack_in = !sda_in;
                     scl_in = 1'b0;
                  end
                  A_SDA_ACK: sda_lvl_in = nack_in;
                  default: ;
               endcase
            end

            // count the wait of the operation
            advance = 1'b1;
            if (op.quarters != 2'd0) begin
               tick_sum = {1'b0, tick_in} + 17'd1;
               if (tick_sum < {1'b0, qt}) begin
                  tick_in = tick_sum[15:0];
                  advance = 1'b0;
               end else begin
                  tick_in     = '0;
                  quarter_sum = quarter_in + 2'd1;
                  if (quarter_sum < op.quarters) begin
                     quarter_in = quarter_sum;
                     advance    = 1'b0;
                  end
               end
            end

            // step to the next operation, then to the next phase
            if (advance) begin
               quarter_in = '0;
               tick_in    = '0;
               if (step_in != len - 3'd1) begin
                  step_in = step_in + 3'd1;
               end else begin
                  step_in = '0;
                  case (phase_in)
                     PH_START: begin
                        if (chain_in) begin
                           chain_in = 1'b0;
                           bit_in   = '0;
                           phase_in = PH_PUT;
                        end else begin
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                        end
                     end
                     PH_PUT: begin
                        if (bit_in == LAST_BIT) begin
                           bit_in   = '0;
                           phase_in = PH_PUTACK;
                        end else begin
                           bit_in = bit_in + 3'd1;
                        end
                     end
                     PH_GET: begin
                        if (bit_in == LAST_BIT) begin
                           bit_in   = '0;
                           rbyte_in = shift_in;
                           phase_in = PH_GETACK;
                        end else begin
                           bit_in = bit_in + 3'd1;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  endcase
               end
            end
         end
      end
   end

   // Hold sequencer state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         step_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         tick_ff    <= '0;
         quarter_ff <= '0;
         nack_ff    <= 1'b0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_lvl_ff <= 1'b1;
         chain_ff   <= 1'b0;
         rbyte_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         tick_ff    <= tick_in;
         quarter_ff <= quarter_in;
         nack_ff    <= nack_in;
         ack_ff     <= ack_in;
         scl_ff     <= scl_in;
         sda_lvl_ff <= sda_lvl_in;
         chain_ff   <= chain_in;
         rbyte_ff   <= rbyte_in;
      end
   end

   assign result = '{scl_release:  scl_in,
                     sda_release:  sda_lvl_in,
                     busy_res:     phase_in != PH_IDLE,
                     done_res:     done,
                     ack_received: ack_in,
                     read_data:    rbyte_in};

   // Idle means no wait is in progress
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_ff == 16'd0 && quarter_ff == 2'd0 && step_ff == 3'd0)
      else $error("idle sequencer with pending wait");

   // A completion needs a running command or one launched this cycle
   a_done_source: assert property (@(posedge clock) disable iff (reset)
      done |-> accept && (phase_ff != PH_IDLE || command != CMD_NONE))
      else $error("completion without a command");

   // A launched command always lasts beyond its first cycle
   a_launch_runs: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_IDLE && command != CMD_NONE && command != CMD_RESERVED
      |=> phase_ff != PH_IDLE)
      else $error("command finished in its first cycle");

   // Bit counting happens only while shifting a byte
   a_bit_phase: assert property (@(posedge clock) disable iff (reset)
      bit_ff != 3'd0 |-> phase_ff == PH_PUT || phase_ff == PH_GET)
      else $error("bit count outside a byte phase");

   // State only moves on an accepted item
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(tick_ff) && $stable(shift_ff))
      else $error("sequencer moved without an item");

endmodule

[sv/i2c_byte_master.sv]
// Channel   Dir  Handshake        Contents
// req_ch    in   valid / ready    command, write_data, send_nack, sda_in
// rsp_ch    out  valid / ready    scl_release, sda_release, busy_res, done_res,
//                                 ack_received, read_data
// csr_*     in   write enable     index 0 quarter_ticks, index 1 device_address
//
// One item per cycle while rsp_ch is not stalled: each accepted item advances the bus
// sequencer and its result appears in the output register on the next cycle.
// Throughput is set by the output register: req_ch.ready is high while the register is
// empty or being drained, so a new item enters every cycle when rsp_ch.ready is high.
// Synchronous reset releases both lines, returns to idle and loads quarter_ticks = 125.
// A stall on rsp_ch holds the sequencer and its divider where they are.
module i2c_byte_master import i2cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cbm_req_if.sink   req_ch,
   i2cbm_rsp_if.source rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] quarter_ticks_ff;
   logic [6:0]  device_address_ff;
   logic        rsp_valid_ff;
   result_type  result_ff;
   result_type  result;
   logic        accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ticks_ff  <= QUARTER_TICKS_RESET;
         device_address_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_QUARTER_TICKS:  quarter_ticks_ff  <= csr_write_data;
            REG_DEVICE_ADDRESS: device_address_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   i2cbm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_ch.command),
      .write_data     (req_ch.write_data),
      .send_nack      (req_ch.send_nack),
      .sda_in         (req_ch.sda_in),
      .quarter_ticks  (quarter_ticks_ff),
      .device_address (device_address_ff),
      .result         (result)
   );

   // Output register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_release  = result_ff.scl_release;
   assign rsp_ch.sda_release  = result_ff.sda_release;
   assign rsp_ch.busy_res     = result_ff.busy_res;
   assign rsp_ch.done_res     = result_ff.done_res;
   assign rsp_ch.ack_received = result_ff.ack_received;
   assign rsp_ch.read_data    = result_ff.read_data;

endmodule

[tb/i2c_byte_master_checker.sv]
`timescale 1ns / 1ps

module i2c_byte_master_checker import i2cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cbm_req_if        req,
   i2cbm_rsp_if        rsp,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   output logic        bus_busy,
   output int          pending,
   output int          fail_count,
   output int          cmds_started,
   output int          results_checked
);

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // One line operation: pin action, quarters to wait, operations in its phase
   typedef struct packed {
      logic [2:0] ops;
      logic [3:0] act;
      logic [1:0] quarters;
   } bus_op_type;

   // Divider and address settings as seen on the register port
   logic [15:0] cfg_quarter = QUARTER_TICKS_RESET;
   logic [6:0]  cfg_address = 7'd0;

   // Sequencer state of the predicted bus master
   logic [2:0]  bus_phase   = PH_IDLE;
   logic [2:0]  op_index    = 3'd0;
   logic [3:0]  bits_done   = 4'd0;
   logic [7:0]  shift_reg   = 8'd0;
   logic [15:0] div_count   = 16'd0;
   logic [1:0]  quarter_idx = 2'd0;
   logic        nack_hold   = 1'b0;
   logic        ack_seen    = 1'b0;
   logic        scl_up      = 1'b1;
   logic        sda_up      = 1'b1;
   logic        chain_addr  = 1'b0;
   logic [7:0]  last_read   = 8'd0;

   result_type line_expect_q[$];
   int errors = 0;
   int results = 0;
   int cmds_seen = 0;

   // Line operation for a given phase and step
   function automatic bus_op_type bus_op(input logic [2:0] ph, input logic [2:0] idx);
      bus_op_type op;
      op.ops = 3'd3;
      op.act = A_NONE;
      op.quarters = 2'd1;
      case (ph)
         PH_START: begin
            op.ops = 3'd4;
            op.quarters = 2'd2;
            case (idx)
               3'd0:    op.act = A_SDA_REL;
               3'd1:    op.act = A_SCL_REL;
               3'd2:    op.act = A_SDA_LOW;
               default: op.act = A_SCL_LOW;
            endcase
         end
         PH_STOP: begin
            op.ops = 3'd4;
            op.quarters = 2'd2;
            case (idx)
               3'd0:    op.act = A_NONE;
               3'd1:    op.act = A_SDA_LOW;
               3'd2:    op.act = A_SCL_REL;
               default: op.act = A_SDA_REL;
            endcase
         end
         PH_PUT: begin
            case (idx)
               3'd0:    op.act = A_SDA_BIT;
               3'd1:    op.act = A_SCL_REL;
               default: begin
                  op.act = A_SCL_LOW;
                  op.quarters = 2'd0;
               end
            endcase
         end
         PH_PUTACK: begin
            case (idx)
               3'd0:    op.act = A_SDA_REL;
               3'd1: begin
                  op.act = A_SCL_REL;
                  op.quarters = 2'd2;
               end
               default: begin
                  op.act = A_ACK_SAMPLE;
                  op.quarters = 2'd0;
               end
            endcase
         end
         PH_GET: begin
            case (idx)
               3'd0:    op.act = A_SDA_REL;
               3'd1:    op.act = A_SCL_SAMPLE;
               default: begin
                  op.act = A_SCL_LOW;
                  op.quarters = 2'd0;
               end
            endcase
         end
         default: begin
            op.ops = 3'd5;
            case (idx)
               3'd0:    op.act = A_NONE;
               3'd1:    op.act = A_SDA_ACK;
               3'd2:    op.act = A_SCL_REL;
               3'd3: begin
                  op.act = A_SCL_LOW;
                  op.quarters = 2'd0;
               end
               default: begin
                  op.act = A_SDA_REL;
                  op.quarters = 2'd0;
               end
            endcase
         end
      endcase
      return op;
   endfunction

   // Advance the predicted master by one clock item and return its pin result
   task automatic tick_model(input logic [2:0] cmd, input logic [7:0] wdata,
                             input logic nack, input logic sda, output result_type res);
      bus_op_type  op;
      logic [15:0] period;
      logic        finished;
      logic        advance;
      finished = 1'b0;
      advance = 1'b1;
      // take a new command only while idle; none and code seven do nothing
      if (bus_phase == PH_IDLE && (cmd inside {[CMD_START:CMD_ADDR_READ]})) begin
         op_index = 3'd0;
         div_count = 16'd0;
         quarter_idx = 2'd0;
         bits_done = 4'd0;
         chain_addr = 1'b0;
         cmds_seen++;
         case (cmd)
            CMD_START: bus_phase = PH_START;
            CMD_STOP:  bus_phase = PH_STOP;
            CMD_WRITE: begin
               shift_reg = wdata;
               bus_phase = PH_PUT;
            end
            CMD_READ: begin
               nack_hold = nack;
               shift_reg = 8'd0;
               bus_phase = PH_GET;
            end
            default: begin
               // address latched now, later register writes do not matter
               shift_reg = {cfg_address, cmd == CMD_ADDR_READ};
               chain_addr = 1'b1;
               bus_phase = PH_START;
            end
         endcase
      end
      if (bus_phase != PH_IDLE) begin
         op = bus_op(bus_phase, op_index);
         period = (cfg_quarter == 16'd0) ? 16'd1 : cfg_quarter;
         // move the pins or sample SDA in the first cycle of an operation only
         if (div_count == 16'd0 && quarter_idx == 2'd0) begin
            case (op.act)
               A_SDA_REL: sda_up = 1'b1;
               A_SDA_LOW: sda_up = 1'b0;
               A_SCL_REL: scl_up = 1'b1;
               A_SCL_LOW: scl_up = 1'b0;
               A_SDA_BIT: begin
                  sda_up = shift_reg[7];
                  shift_reg = shift_reg << 1;
               end
               A_SCL_SAMPLE: begin
                  scl_up = 1'b1;
                  shift_reg = {shift_reg[6:0], sda};
               end
               A_ACK_SAMPLE: begin
                  ack_seen = ~sda;
                  scl_up = 1'b0;
               end
               A_SDA_ACK: sda_up = nack_hold;
               default: ;
            endcase
         end
         // count out the quarters of this operation
         if (op.quarters != 2'd0) begin
            div_count++;
            if (div_count < period) begin
               advance = 1'b0;
            end else begin
               div_count = 16'd0;
               quarter_idx++;
               if (quarter_idx < op.quarters)
                  advance = 1'b0;
            end
         end
         if (advance) begin
            div_count = 16'd0;
            quarter_idx = 2'd0;
            op_index++;
            if (op_index == op.ops) begin
               op_index = 3'd0;
               finished = 1'b1;
               // chain into the next phase or finish the command
               case (bus_phase)
                  PH_START: begin
                     if (chain_addr) begin
                        chain_addr = 1'b0;
                        bits_done = 4'd0;
                        bus_phase = PH_PUT;
                        finished = 1'b0;
                     end
                  end
                  PH_PUT: begin
                     finished = 1'b0;
                     bits_done++;
                     if (bits_done == BITS_PER_BYTE) begin
                        bits_done = 4'd0;
                        bus_phase = PH_PUTACK;
                     end
                  end
                  PH_GET: begin
                     finished = 1'b0;
                     bits_done++;
                     if (bits_done == BITS_PER_BYTE) begin
                        bits_done = 4'd0;
                        last_read = shift_reg;
                        bus_phase = PH_GETACK;
                     end
                  end
                  default: ;
               endcase
               if (finished)
                  bus_phase = PH_IDLE;
            end
         end
      end
      res.scl_release = scl_up;
      res.sda_release = sda_up;
      res.busy_res = (bus_phase != PH_IDLE);
      res.done_res = finished;
      res.ack_received = ack_seen;
      res.read_data = last_read;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= 10)
            $display("%0t: result %0d field %s: expected 0x%0h, got 0x%0h",
                     $realtime, results, name, want, got);
      end
   endtask

   // Track register writes, predict accepted items, compare accepted results
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_quarter = QUARTER_TICKS_RESET;
         cfg_address = 7'd0;
         bus_phase = PH_IDLE;
         op_index = 3'd0;
         bits_done = 4'd0;
         shift_reg = 8'd0;
         div_count = 16'd0;
         quarter_idx = 2'd0;
         nack_hold = 1'b0;
         ack_seen = 1'b0;
         scl_up = 1'b1;
         sda_up = 1'b1;
         chain_addr = 1'b0;
         last_read = 8'd0;
         line_expect_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == REG_QUARTER_TICKS)
               cfg_quarter = csr_write_data;
            else
               cfg_address = csr_write_data[6:0];
         end
         // compare before predicting: an item never comes out on its own edge
         if (rsp.valid && rsp.ready) begin
            if (line_expect_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result arrived with no item waiting", $realtime);
            end else begin
               want = line_expect_q.pop_front();
               compare_field("scl_release", want.scl_release, rsp.scl_release);
               compare_field("sda_release", want.sda_release, rsp.sda_release);
               compare_field("busy_res", want.busy_res, rsp.busy_res);
               compare_field("done_res", want.done_res, rsp.done_res);
               compare_field("ack_received", want.ack_received, rsp.ack_received);
               compare_field("read_data", want.read_data, rsp.read_data);
            end
            results++;
         end
         if (req.valid && req.ready) begin
            tick_model(req.command, req.write_data, req.send_nack, req.sda_in, want);
            line_expect_q.push_back(want);
         end
      end
      bus_busy <= (bus_phase != PH_IDLE);
      pending <= line_expect_q.size();
      fail_count <= errors;
      cmds_started <= cmds_seen;
      results_checked <= results;
   end

endmodule

[tb/tb_i2c_byte_master.sv]
`timescale 1ns / 1ps

module tb_i2c_byte_master;
   import i2cbm_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_GAP     = 20;

   typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_type;

   typedef struct {
      logic [2:0] cmd;
      logic [7:0] data;
      logic       nack;
   } bus_cmd_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_write_data;

   logic bus_busy;
   int   pending;
   int   fail_count;
   int   cmds_started;
   int   results_checked;

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   bit hold_req = 1'b0;
   bit hold_served = 1'b0;
   int items_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   i2cbm_req_if req_ch ();
   i2cbm_rsp_if rsp_ch ();

   i2c_byte_master i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   i2c_byte_master_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .bus_busy        (bus_busy),
      .pending         (pending),
      .fail_count      (fail_count),
      .cmds_started    (cmds_started),
      .results_checked (results_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive result-side ready: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Drop the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("i2c_byte_master test failed");
         $finish;
      end
   end

   function automatic logic line_level(input line_mode_type mode);
      logic lvl;
      case (mode)
         LINE_LOW:  lvl = 1'b0;
         LINE_HIGH: lvl = 1'b1;
         default:   lvl = 1'($urandom_range(1));
      endcase
      return lvl;
   endfunction

   // Offer one clock item, with an optional idle gap first; return once accepted
   task automatic send_tick(input logic [2:0] cmd, input logic [7:0] data,
                            input logic nack, input logic sda);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.write_data <= data;
      req_ch.send_nack <= nack;
      req_ch.sda_in <= sda;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Feed empty items until the predicted master is idle; ends on a rising edge
   task automatic run_until_idle(input line_mode_type mode);
      bit going;
      going = 1'b1;
      while (going) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
         going = bus_busy;
         @(posedge clock);
         if (going)
            send_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      line_level(mode));
      end
   endtask

   task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] data,
                          input logic nack, input line_mode_type mode);
      send_tick(cmd, data, nack, line_level(mode));
      run_until_idle(mode);
   endtask

   // Write both registers while idle; ends on a rising edge
   task automatic configure(input logic [15:0] quarter, input logic [6:0] address);
      csr_write_en <= 1'b1;
      csr_index <= REG_QUARTER_TICKS;
      csr_write_data <= quarter;
      @(posedge clock);
      csr_index <= REG_DEVICE_ADDRESS;
      csr_write_data <= {9'd0, address};
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed transfers with random content, some noise between them
   task automatic run_traffic(input int n);
      bus_cmd_type plan[$];
      bus_cmd_type e;
      int          sent;
      int          nbytes;
      bit          fresh;
      bit          is_read;
      sent = 0;
      fresh = 1'b0;
      while (sent < n) begin
         if (plan.size() == 0) begin
            if ($urandom_range(99) < 80) begin
               is_read = 1'($urandom_range(1));
               e.cmd = is_read ? CMD_ADDR_READ : CMD_ADDR_WRITE;
               e.data = 8'($urandom_range(255));
               e.nack = 1'($urandom_range(1));
               plan.push_back(e);
               nbytes = $urandom_range(1, 3);
               for (int i = 0; i < nbytes; i++) begin
                  e.cmd = is_read ? CMD_READ : CMD_WRITE;
                  e.data = 8'($urandom_range(255));
                  e.nack = (i == nbytes - 1);
                  plan.push_back(e);
               end
               e.cmd = CMD_STOP;
               plan.push_back(e);
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  e.cmd = 3'($urandom_range(7));
                  e.data = 8'($urandom_range(255));
                  e.nack = 1'($urandom_range(1));
                  plan.push_back(e);
               end
            end
         end
         // busy is known one item late, so follow each command with a filler
         if (fresh || bus_busy) begin
            e.cmd = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : CMD_NONE;
            e.data = 8'($urandom_range(255));
            e.nack = 1'($urandom_range(1));
            fresh = 1'b0;
         end else begin
            e = plan.pop_front();
            fresh = 1'b1;
         end
         send_tick(e.cmd, e.data, e.nack, 1'($urandom_range(1)));
         sent++;
      end
   endtask

   // Settle, write the registers, then run traffic; optionally start the long hold-off
   task automatic run_phase(input logic [15:0] quarter, input logic [6:0] address,
                            input int tx_pct, input int rx_pct, input int n,
                            input bit hold_off);
      run_until_idle(LINE_RANDOM);
      while (pending != 0)
         @(negedge clock);
      @(posedge clock);
      configure(quarter, address);
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      if (hold_off)
         hold_req = 1'b1;
      run_traffic(n);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_NONE;
      req_ch.write_data <= 8'd0;
      req_ch.send_nack <= 1'b0;
      req_ch.sda_in <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= REG_QUARTER_TICKS;
      csr_write_data <= 16'd0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero divider is treated as a divider of one, address left at reset
      configure(16'd0, 7'd0);
      run_cmd(CMD_START, 8'h00, 1'b0, LINE_HIGH);
      run_cmd(CMD_ADDR_WRITE, 8'h00, 1'b0, LINE_LOW);
      run_cmd(CMD_WRITE, 8'hFF, 1'b0, LINE_HIGH);
      run_cmd(CMD_WRITE, 8'h00, 1'b1, LINE_LOW);
      run_cmd(CMD_WRITE, 8'hA5, 1'b0, LINE_RANDOM);
      run_cmd(CMD_READ, 8'h00, 1'b0, LINE_HIGH);
      run_cmd(CMD_READ, 8'hFF, 1'b1, LINE_LOW);
      run_cmd(CMD_READ, 8'h5A, 1'b1, LINE_RANDOM);
      run_cmd(CMD_STOP, 8'h00, 1'b0, LINE_HIGH);
      // code seven and none leave the master idle
      run_cmd(CMD_RESERVED, 8'hFF, 1'b1, LINE_RANDOM);
      run_cmd(CMD_NONE, 8'h81, 1'b1, LINE_RANDOM);
      // the first command starts; the commands offered while busy are dropped
      send_tick(CMD_ADDR_READ, 8'h00, 1'b0, 1'b0);
      send_tick(CMD_WRITE, 8'hC3, 1'b0, 1'b0);
      send_tick(CMD_STOP, 8'h00, 1'b1, 1'b0);
      run_until_idle(LINE_LOW);
      run_cmd(CMD_READ, 8'h00, 1'b1, LINE_RANDOM);
      run_cmd(CMD_STOP, 8'h00, 1'b0, LINE_RANDOM);

      // random traffic over several divider and address settings
      run_phase(16'd1, 7'h55, 0, 0, 230, 1'b0);
      run_phase(16'd2, 7'h2A, 51, 0, 230, 1'b0);
      run_phase(16'd0, 7'h7F, 0, 51, 230, 1'b0);
      run_phase(16'd3, 7'($urandom_range(127)), 27, 27, 230, 1'b1);
      // widest divider: a command gets under way but cannot finish in the run
      run_phase(16'hFFFF, 7'd0, 0, 0, 150, 1'b0);

      req_ch.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d clock items and %0d checked results over %0d register settings",
               items_sent, results_checked, settings_used);
      $display("%0d bus commands started, with a %0d-cycle output hold-off under load",
               cmds_started, HOLD_CYCLES);
      if (fail_count == 0)
         $display("i2c_byte_master test passed");
      else
         $display("i2c_byte_master test failed");
      $finish;
   end

endmodule

[i2c_byte_master.f]
sv/i2cbm_pkg.sv
sv/i2cbm_if.sv
sv/i2cbm_core.sv
sv/i2c_byte_master.sv
tb/i2c_byte_master_checker.sv
tb/tb_i2c_byte_master.sv
